@@ hw/rtl/etaa_pkg.sv @@
// Shared types, widths, register indexes and reset values of the exposure control block.
`default_nettype none

package etaa_pkg;

	localparam int TIME_BITS      = 24;
	localparam int PIXEL_BITS     = 16;
	localparam int THR_BITS       = 16;
	localparam int TRY_BITS       = 5;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = TIME_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_THRESHOLD = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_THRESHOLD = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_ITIME       = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ITIME       = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_TRIES       = 3'd4;

	localparam logic [THR_BITS-1:0]  LOWER_THRESHOLD_RST = THR_BITS'(33000);
	localparam logic [THR_BITS-1:0]  UPPER_THRESHOLD_RST = THR_BITS'(54600);
	localparam logic [TIME_BITS-1:0] MIN_ITIME_RST       = TIME_BITS'(54000);
	localparam logic [TIME_BITS-1:0] MAX_ITIME_RST       = TIME_BITS'(1000000);
	localparam logic [TRY_BITS-1:0]  MAX_TRIES_RST       = TRY_BITS'(16);

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	typedef struct packed {
		logic                  action;
		logic [PIXEL_BITS-1:0] pixel_value;
		logic                  frame_last;
	} in_item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] integration_time;
		logic                 is_final;
	} out_item_t;

	typedef struct packed {
		logic [THR_BITS-1:0]  lower_threshold;
		logic [THR_BITS-1:0]  upper_threshold;
		logic [TIME_BITS-1:0] min_itime;
		logic [TIME_BITS-1:0] max_itime;
		logic [TRY_BITS-1:0]  max_tries;
	} cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/etaa_cfg.sv @@
// Configuration register file of the exposure control block.
`default_nettype none

module etaa_cfg (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire [etaa_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire [etaa_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
	output etaa_pkg::cfg_t                        cfg
);
	import etaa_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_threshold <= LOWER_THRESHOLD_RST;
			cfg_q.upper_threshold <= UPPER_THRESHOLD_RST;
			cfg_q.min_itime       <= MIN_ITIME_RST;
			cfg_q.max_itime       <= MAX_ITIME_RST;
			cfg_q.max_tries       <= MAX_TRIES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOWER_THRESHOLD: cfg_q.lower_threshold <= cfg_wdata[THR_BITS-1:0];
				REG_UPPER_THRESHOLD: cfg_q.upper_threshold <= cfg_wdata[THR_BITS-1:0];
				REG_MIN_ITIME:       cfg_q.min_itime       <= cfg_wdata[TIME_BITS-1:0];
				REG_MAX_ITIME:       cfg_q.max_itime       <= cfg_wdata[TIME_BITS-1:0];
				REG_MAX_TRIES:       cfg_q.max_tries       <= cfg_wdata[TRY_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/etaa_ctrl.sv @@
// Run state, peak tracking, frame-end decision and result register.
`default_nettype none

module etaa_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  etaa_pkg::cfg_t       cfg,
	input  wire                  in_valid,
	input  etaa_pkg::in_item_t   in_item,
	output logic                 take,
	output logic                 out_valid,
	input  wire                  out_ready,
	output etaa_pkg::out_item_t  out_item
);
	import etaa_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FIRST,
		PH_PROBE_UP,
		PH_PROBE_DOWN,
		PH_SEARCH
	} phase_t;

	typedef enum logic [1:0] {
		DIR_FOUND,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef logic [TIME_BITS:0] time_ext_t;

	phase_t                phase_q, phase_d;
	logic [PIXEL_BITS-1:0] peak_q, peak_d, peak_new;
	logic [TIME_BITS-1:0]  cur_q, cur_d;
	logic [TIME_BITS-1:0]  step_q, step_d;
	logic [TRY_BITS-1:0]   try_q, try_d, try_inc;
	logic                  out_valid_q;
	out_item_t             out_item_q;
	out_item_t             res;
	logic                  produces;
	dir_t                  dir;
	logic [TIME_BITS-1:0]  half, step_h, bs_up, bs_down;
	time_ext_t             t_up, t_dn, t_nx, min_plus;
	logic                  ge_max, le_min;

	always_comb begin
		half     = cfg.max_itime >> 1;
		peak_new = (in_item.pixel_value > peak_q) ? in_item.pixel_value : peak_q;
		if ({{(THR_BITS > PIXEL_BITS ? THR_BITS - PIXEL_BITS : 0){1'b0}}, peak_new} >
				cfg.upper_threshold) begin
			dir = DIR_DOWN;
		end else if ({{(THR_BITS > PIXEL_BITS ? THR_BITS - PIXEL_BITS : 0){1'b0}}, peak_new} <
				cfg.lower_threshold) begin
			dir = DIR_UP;
		end else begin
			dir = DIR_FOUND;
		end
		step_h   = step_q >> 1;
		try_inc  = try_q + TRY_BITS'(1);
		t_up     = {1'b0, cur_q} + {1'b0, step_h};
		min_plus = {1'b0, cfg.min_itime} + {1'b0, step_h};
		t_dn     = ({1'b0, cur_q} > min_plus) ? ({1'b0, cur_q} - {1'b0, step_h})
			: {1'b0, cfg.min_itime};
		t_nx     = (dir == DIR_UP) ? t_up : t_dn;
		ge_max   = t_nx >= {1'b0, cfg.max_itime};
		le_min   = t_nx <= {1'b0, cfg.min_itime};
		bs_up    = (cfg.max_itime > half) ? ((cfg.max_itime - half) >> 1) : '0;
		bs_down  = (half > cfg.min_itime) ? ((half - cfg.min_itime) >> 1) : '0;
	end

	always_comb begin
		phase_d  = phase_q;
		peak_d   = peak_q;
		cur_d    = cur_q;
		step_d   = step_q;
		try_d    = try_q;
		produces = 1'b0;
		res      = '{integration_time: cur_q, is_final: 1'b0};
		if (in_item.action == ACT_START) begin
			peak_d   = '0;
			step_d   = '0;
			try_d    = '0;
			cur_d    = half;
			phase_d  = PH_FIRST;
			produces = 1'b1;
			res      = '{integration_time: half, is_final: 1'b0};
		end else if (phase_q != PH_IDLE) begin
			peak_d = peak_new;
			if (in_item.frame_last) begin
				peak_d       = '0;
				produces     = 1'b1;
				res.is_final = 1'b1;
				case (phase_q)
					PH_FIRST: begin
						if (dir == DIR_UP) begin
							cur_d   = cfg.max_itime;
							phase_d = PH_PROBE_UP;
							res     = '{integration_time: cfg.max_itime, is_final: 1'b0};
						end else if (dir == DIR_DOWN) begin
							cur_d   = cfg.min_itime;
							phase_d = PH_PROBE_DOWN;
							res     = '{integration_time: cfg.min_itime, is_final: 1'b0};
						end
					end
					PH_PROBE_UP: begin
						if (dir == DIR_DOWN) begin
							cur_d  = half;
							step_d = bs_up;
							try_d  = '0;
							res    = '{integration_time: half,
								is_final: (cfg.max_tries == '0)};
							if (cfg.max_tries != '0) begin
								phase_d = PH_SEARCH;
							end
						end
					end
					PH_PROBE_DOWN: begin
						if (dir == DIR_UP) begin
							cur_d  = cfg.min_itime;
							step_d = bs_down;
							try_d  = '0;
							res    = '{integration_time: cfg.min_itime,
								is_final: (cfg.max_tries == '0)};
							if (cfg.max_tries != '0) begin
								phase_d = PH_SEARCH;
							end
						end
					end
					PH_SEARCH: begin
						try_d  = try_inc;
						step_d = step_h;
						if (dir != DIR_FOUND) begin
							if (ge_max) begin
								cur_d                = cfg.max_itime;
								res.integration_time = cfg.max_itime;
							end else if (le_min) begin
								cur_d                = cfg.min_itime;
								res.integration_time = cfg.min_itime;
							end else begin
								cur_d                = t_nx[TIME_BITS-1:0];
								res.integration_time = t_nx[TIME_BITS-1:0];
								res.is_final         = (try_inc >= cfg.max_tries);
							end
						end
					end
					default: begin
					end
				endcase
				if (res.is_final) begin
					phase_d = PH_IDLE;
				end
			end
		end
	end

	assign take = in_valid && (!produces || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			peak_q      <= '0;
			cur_q       <= '0;
			step_q      <= '0;
			try_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				phase_q <= phase_d;
				peak_q  <= peak_d;
				cur_q   <= cur_d;
				step_q  <= step_d;
				try_q   <= try_d;
				if (produces) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && produces) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(take && produces))
		else $error("A waiting result item was overwritten.");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_item.action == ACT_START |=> out_valid_q && !out_item_q.is_final
			&& phase_q == PH_FIRST)
		else $error("A start item did not give an open first result.");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && produces && res.is_final |=> phase_q == PH_IDLE && out_item_q.is_final)
		else $error("A final result did not end the run.");

	a_idle_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE && in_item.action == ACT_PIXEL |-> !produces)
		else $error("A pixel item outside a run gave a result.");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/exposure_time_auto_adjust_core.sv @@
// Top level of the automatic exposure control block: input register and submodules.
// Usage:
// The input channel carries start items (action 0) and pixel items (action 1) on a
// valid/ready handshake. A start item opens a run and yields a first integration time
// of half the longest allowed time. Pixels of each measured frame are reduced to their
// peak; the pixel marked last in a frame yields the next integration time to measure,
// or the final time with is_final set, which ends the run. Pixels outside a run are
// dropped without a result.
// An accepted item is held in an input register and decided from it; its result item
// is registered in the output register and offered on the output channel from there.
// One item is accepted every cycle while the output is taken; the frame-end decision
// is a single pass through the peak compare and the search adder.
// When the receiver stalls, a waiting result is held in the output register; items
// that give no result still pass, and the input stalls only when the next item would
// need the occupied output register.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while no item is
// in flight. Reset clears the run to idle, empties both registers and loads the
// default thresholds, time limits and try count.
`default_nettype none

module exposure_time_auto_adjust_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  etaa_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  wire                                out_ready,
	output etaa_pkg::out_item_t                out_item,
	input  wire                                cfg_we,
	input  wire [etaa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire [etaa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import etaa_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     take;
	cfg_t     cfg;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	etaa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	etaa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (valid_s1),
		.in_item   (item_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire
